// ===== rtl/core/multidim_histogram_bin_lookup_defines.svh =====
// Assertion macros for the histogram bin lookup checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef MULTIDIM_HISTOGRAM_BIN_LOOKUP_DEFINES_SVH
`define MULTIDIM_HISTOGRAM_BIN_LOOKUP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define MHBL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mhbl assertion failed");

// Implication whose consequence is checked in the following cycle.
`define MHBL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mhbl assertion failed");

// Implication checked during reset too, consequence in the following cycle.
`define MHBL_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk_i) (ante) |=> (cons)) \
    else $error("mhbl assertion failed");

`endif

// ===== rtl/core/mhbl_pkg.sv =====
// Package for the histogram bin lookup: item types, opcodes, FSM states
// and default sizes. No dependencies.
`default_nettype none

package mhbl_pkg;

  localparam int MhblMaxDims       = 4;
  localparam int MhblMaxBinsPerDim = 16;
  localparam int MhblMaxTypes      = 4;
  localparam int QueueDepth        = 2;
  localparam int NumCoords         = 4;

  typedef enum logic [1:0] {
    ACT_EDGE   = 2'd0,
    ACT_COUNT  = 2'd1,
    ACT_HEADER = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_EDGE,
    OP_COUNT,
    OP_HEADER,
    OP_LOOKUP,
    OP_MISS
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIM,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         bin_type;
    logic [1:0]         dim_sel;
    logic [3:0]         entry_sel;
    logic signed [31:0] write_value;
    logic [2:0]         dims_in_use;
    logic signed [31:0] coord_0;
    logic signed [31:0] coord_1;
    logic signed [31:0] coord_2;
    logic signed [31:0] coord_3;
  } in_item_t;

  typedef struct packed {
    logic [15:0] bin_address;
    logic        found;
  } res_item_t;

  // Classified item as it waits between front and back.
  typedef struct packed {
    op_e                          op;
    logic [1:0]                   bin_type;
    logic [1:0]                   dim_sel;
    logic [3:0]                   entry_sel;
    logic signed [31:0]           write_value;
    logic [2:0]                   dims;
    logic [NumCoords-1:0][31:0]   coords;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } head_t;

endpackage

`default_nettype wire

// ===== rtl/core/mhbl_front.sv =====
// Front end: classifies input beats and buffers them in a short queue.
// Depends on mhbl_pkg.
`default_nettype none

module mhbl_front import mhbl_pkg::*; #(
  parameter int MAX_DIMS         = MhblMaxDims,
  parameter int MAX_BINS_PER_DIM = MhblMaxBinsPerDim,
  parameter int MAX_TYPES        = MhblMaxTypes
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  output logic          full_o,
  input  wire in_item_t in_item_i,
  output head_t         head_o,
  input  wire logic     deq_i
);

  localparam int QW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  work_t             cls;
  work_t             q_mem [QueueDepth];
  logic [QW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QW:0]       cnt_q, cnt_d;
  logic              enq, deq, t_ok, d_ok, e_ok;

  assign t_ok = 32'(in_item_i.bin_type) < MAX_TYPES;
  assign d_ok = 32'(in_item_i.dim_sel) < MAX_DIMS;
  assign e_ok = 32'(in_item_i.entry_sel) < MAX_BINS_PER_DIM;

  always_comb begin
    cls.bin_type    = in_item_i.bin_type;
    cls.dim_sel     = in_item_i.dim_sel;
    cls.entry_sel   = in_item_i.entry_sel;
    cls.write_value = in_item_i.write_value;
    cls.dims        = (32'(in_item_i.dims_in_use) > MAX_DIMS) ? 3'(MAX_DIMS)
                                                              : in_item_i.dims_in_use;
    cls.coords      = {in_item_i.coord_3, in_item_i.coord_2,
                       in_item_i.coord_1, in_item_i.coord_0};
    case (in_item_i.action)
      ACT_EDGE:   cls.op = (t_ok && d_ok && e_ok) ? OP_EDGE : OP_NOP;
      ACT_COUNT:  cls.op = (t_ok && d_ok) ? OP_COUNT : OP_NOP;
      ACT_HEADER: cls.op = t_ok ? OP_HEADER : OP_NOP;
      ACT_LOOKUP: cls.op = t_ok ? OP_LOOKUP : OP_MISS;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign full_o = cnt_q == (QW+1)'(QueueDepth);
  assign enq    = push_i && !full_o;
  assign deq    = deq_i && (cnt_q != '0);

  assign head_o.valid = cnt_q != '0;
  assign head_o.work  = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (enq) begin
      wr_ptr_d = (32'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (deq) begin
      rd_ptr_d = (32'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + (QW+1)'(enq) - (QW+1)'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mhbl_back.sv =====
// Back end: holds the type tables and edge memory, executes writes and
// walks lookups one edge at a time. Depends on mhbl_pkg.
`default_nettype none

module mhbl_back import mhbl_pkg::*; #(
  parameter int MAX_DIMS         = MhblMaxDims,
  parameter int MAX_BINS_PER_DIM = MhblMaxBinsPerDim,
  parameter int MAX_TYPES        = MhblMaxTypes
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire head_t head_i,
  output logic       deq_o,
  output logic       empty_o,
  input  wire logic  pop_i,
  output res_item_t  res_o
);

  localparam int TW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int JW = $clog2(MAX_BINS_PER_DIM);
  localparam int CW = $clog2(MAX_BINS_PER_DIM + 1);
  localparam int NR = MAX_TYPES * MAX_DIMS;
  localparam int RW = (NR > 1) ? $clog2(NR) : 1;
  localparam int NE = NR * MAX_BINS_PER_DIM;
  localparam int AW = $clog2(NE);

  state_e             state_q, state_d;
  work_t              item_q;
  logic [CW-1:0]      bpd_q [NR];
  logic [2:0]         tdim_q [MAX_TYPES];
  logic [15:0]        toff_q [MAX_TYPES];
  logic [31:0]        edge_mem [NE];
  logic signed [31:0] edge_rd_q;
  logic [2:0]         dim_q;
  logic [JW-1:0]      j_q;
  logic               prev_ge_q, fail_q, ovf_q, res_valid_q;
  logic [15:0]        acc_q;
  res_item_t          res_q;

  logic [TW-1:0]      t_w, t_l;
  logic [RW-1:0]      row_w, row_l;
  logic [AW-1:0]      waddr, raddr;
  logic [CW-1:0]      nb, cnt_w;
  logic [15:0]        off_w;
  logic signed [31:0] coord;
  logic               ge, last, hit_prev, hit_last, hit, miss, out_free;
  logic               mem_we, cnt_we, hdr_we, take_lookup, res_load;
  logic [JW-1:0]      idx;
  logic [31:0]        prod;
  logic [16:0]        sum;

  assign t_w   = TW'(head_i.work.bin_type);
  assign row_w = RW'(32'(t_w) * MAX_DIMS + 32'(DW'(head_i.work.dim_sel)));
  assign waddr = AW'(32'(row_w) * MAX_BINS_PER_DIM + 32'(JW'(head_i.work.entry_sel)));
  assign t_l   = TW'(item_q.bin_type);
  assign row_l = RW'(32'(t_l) * MAX_DIMS + 32'(DW'(dim_q)));
  assign raddr = AW'(32'(row_l) * MAX_BINS_PER_DIM + 32'(j_q));
  assign nb    = bpd_q[row_l];

  // Clamp counts and offsets on the way into the tables.
  assign cnt_w = (head_i.work.write_value < 0) ? '0 :
                 (head_i.work.write_value > MAX_BINS_PER_DIM) ? CW'(MAX_BINS_PER_DIM) :
                 CW'(head_i.work.write_value);
  assign off_w = (head_i.work.write_value < 0) ? '0 :
                 (head_i.work.write_value > 32'sd65535) ? 16'hFFFF :
                 head_i.work.write_value[15:0];

  // Dimensions past the coordinate fields search with coordinate zero.
  assign coord    = (dim_q < 3'(NumCoords)) ? $signed(item_q.coords[dim_q[1:0]]) : '0;
  assign ge       = coord >= edge_rd_q;
  assign last     = 32'(j_q) + 1 == 32'(nb);
  assign hit_prev = (j_q != '0) && prev_ge_q && !ge;
  assign hit_last = last && ge;
  assign hit      = hit_prev || hit_last;
  assign miss     = last && !hit;
  assign idx      = hit_prev ? j_q - 1'b1 : j_q;
  assign prod     = 32'(acc_q) * 32'(nb) + 32'(idx);
  assign sum      = 17'(toff_q[t_l]) + 17'(acc_q);
  assign out_free = !res_valid_q || pop_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          case (head_i.work.op)
            OP_LOOKUP: state_d = (tdim_q[t_w] == '0) ? ST_EMIT : ST_DIM;
            OP_MISS:   state_d = ST_EMIT;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIM:  state_d = (nb == '0) ? ST_EMIT : ST_READ;
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        if (miss) begin
          state_d = ST_EMIT;
        end else if (hit) begin
          state_d = (dim_q + 3'd1 == tdim_q[t_l]) ? ST_EMIT : ST_DIM;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_EMIT: state_d = out_free ? ST_IDLE : ST_EMIT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    deq_o       = (state_q == ST_IDLE) && head_i.valid;
    mem_we      = deq_o && (head_i.work.op == OP_EDGE);
    cnt_we      = deq_o && (head_i.work.op == OP_COUNT);
    hdr_we      = deq_o && (head_i.work.op == OP_HEADER);
    take_lookup = deq_o && ((head_i.work.op == OP_LOOKUP) || (head_i.work.op == OP_MISS));
    res_load    = (state_q == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      for (int i = 0; i < NR; i++) begin
        bpd_q[i] <= '0;
      end
      for (int i = 0; i < MAX_TYPES; i++) begin
        tdim_q[i] <= '0;
        toff_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
      if (cnt_we) begin
        bpd_q[row_w] <= cnt_w;
      end
      if (hdr_we) begin
        tdim_q[t_w] <= head_i.work.dims;
        toff_q[t_w] <= off_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      edge_mem[waddr] <= head_i.work.write_value;
    end
    edge_rd_q <= edge_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (take_lookup) begin
      item_q <= head_i.work;
      fail_q <= (head_i.work.op == OP_MISS) || (tdim_q[t_w] == '0);
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      dim_q  <= '0;
    end
    if (state_q == ST_DIM) begin
      j_q       <= '0;
      prev_ge_q <= 1'b0;
      if (nb == '0) begin
        fail_q <= 1'b1;
      end
    end
    if (state_q == ST_CMP) begin
      if (miss) begin
        fail_q <= 1'b1;
      end else if (hit) begin
        // Fold this dimension in: last dimension changes fastest.
        acc_q <= prod[15:0];
        ovf_q <= ovf_q || (prod > 32'd65535);
        dim_q <= dim_q + 3'd1;
      end else begin
        j_q       <= j_q + 1'b1;
        prev_ge_q <= ge;
      end
    end
    if (res_load) begin
      res_q.found       <= !fail_q && !ovf_q && !sum[16];
      res_q.bin_address <= (!fail_q && !ovf_q && !sum[16]) ? sum[15:0] : '0;
    end
  end

  assign empty_o = !res_valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/multidim_histogram_bin_lookup.sv =====
// Top level of the histogram bin lookup: front queue plus back executor.
// Depends on mhbl_pkg, mhbl_front and mhbl_back.
//
//   channel   handshake        payload
//   input     push_i / full_o  in_item_i (in_item_t)
//   result    empty_o / pop_i  res_o (res_item_t)
//
// Write beats retire from the queue head while the back end is idle. A lookup
// walks its dimensions in turn: ST_DIM opens each, then ST_READ and ST_CMP
// alternate per edge scanned; ST_EMIT then hands over the result. Reset clears
// tables, queue and result; edges stay undefined until written. The two-entry
// queue keeps input beats moving while the back end searches or awaits a pop.
`default_nettype none

module multidim_histogram_bin_lookup import mhbl_pkg::*; #(
  parameter int MAX_DIMS         = MhblMaxDims,
  parameter int MAX_BINS_PER_DIM = MhblMaxBinsPerDim,
  parameter int MAX_TYPES        = MhblMaxTypes
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  output logic          full_o,
  input  wire in_item_t in_item_i,
  output logic          empty_o,
  input  wire logic     pop_i,
  output res_item_t     res_o
);

  head_t head;
  logic  deq;

  mhbl_front #(
    .MAX_DIMS        (MAX_DIMS),
    .MAX_BINS_PER_DIM(MAX_BINS_PER_DIM),
    .MAX_TYPES       (MAX_TYPES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .full_o   (full_o),
    .in_item_i(in_item_i),
    .head_o   (head),
    .deq_i    (deq)
  );

  mhbl_back #(
    .MAX_DIMS        (MAX_DIMS),
    .MAX_BINS_PER_DIM(MAX_BINS_PER_DIM),
    .MAX_TYPES       (MAX_TYPES)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .deq_o  (deq),
    .empty_o(empty_o),
    .pop_i  (pop_i),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/mhbl_checker.sv =====
// Port-level checks for the histogram bin lookup, bound to the top level.
// Depends on mhbl_pkg and the defines header.
`default_nettype none
`include "multidim_histogram_bin_lookup_defines.svh"

module mhbl_checker import mhbl_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      full_o,
  input wire logic      empty_o,
  input wire logic      pop_i,
  input wire res_item_t res_o
);

  `MHBL_ASSERT_IMP(a_miss_zero, !empty_o && !res_o.found, res_o.bin_address == 16'd0)
  `MHBL_ASSERT_NXT(a_res_hold, !empty_o && !pop_i, !empty_o && $stable(res_o))
  `MHBL_ASSERT_RST(a_reset_clear, !rst_ni, empty_o && !full_o)

endmodule

bind multidim_histogram_bin_lookup mhbl_checker u_mhbl_checker (.*);

`default_nettype wire

// ===== dv/multidim_histogram_bin_lookup_test.sv =====
// Self-checking bench for the histogram bin lookup: loads bin tables through
// write beats and checks every lookup result. Depends on mhbl_pkg and the RTL.
`timescale 1ns / 1ps

module multidim_histogram_bin_lookup_test;
  import mhbl_pkg::*;

  localparam int NTypes = MhblMaxTypes;
  localparam int NDims  = MhblMaxDims;
  localparam int NBins  = MhblMaxBinsPerDim;
  localparam longint CycleLimit = 3000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push_i = 1'b0;
  logic      pop_i = 1'b0;
  in_item_t  in_item_i = '0;
  logic      full_o, empty_o;
  res_item_t res_o;

  multidim_histogram_bin_lookup dut (
    .clk_i, .rst_ni, .push_i, .full_o, .in_item_i, .empty_o, .pop_i, .res_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow tables of the block.
  logic signed [31:0] edge_tbl [NTypes][NDims][NBins];
  bit                 edge_set [NTypes][NDims][NBins];
  logic [4:0]         bin_cnt  [NTypes][NDims];
  logic [2:0]         type_dims[NTypes];
  logic [15:0]        type_off [NTypes];

  in_item_t  pending_items[$];
  res_item_t expected_bins[$];
  int        mismatches = 0;
  bit        stim_done = 1'b0;
  bit        hold_pop = 1'b0;
  longint    cycles = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  function automatic int search_bin(int t, int d, logic signed [31:0] c);
    int nb;
    nb = bin_cnt[t][d];
    for (int j = 0; j < nb; j++) begin
      if (c < edge_tbl[t][d][j]) continue;
      if (j == nb - 1 || c < edge_tbl[t][d][j + 1]) return j;
    end
    return -1;
  endfunction

  // Update the shadow tables; return 1 with the expected result for lookups.
  function automatic bit predict_bin(input in_item_t it, output res_item_t r);
    int t, nd, idx[NDims];
    longint addr, factor;
    logic signed [31:0] c[4];
    t = it.bin_type;
    r = '0;
    c[0] = it.coord_0; c[1] = it.coord_1; c[2] = it.coord_2; c[3] = it.coord_3;
    case (action_e'(it.action))
      ACT_EDGE: begin
        edge_tbl[t][it.dim_sel][it.entry_sel] = it.write_value;
        edge_set[t][it.dim_sel][it.entry_sel] = 1'b1;
        return 1'b0;
      end
      ACT_COUNT: begin
        bin_cnt[t][it.dim_sel] = it.write_value < 0 ? 5'd0 :
            (it.write_value > NBins ? 5'(NBins) : 5'(it.write_value));
        return 1'b0;
      end
      ACT_HEADER: begin
        type_dims[t] = it.dims_in_use > NDims ? 3'(NDims) : it.dims_in_use;
        type_off[t] = it.write_value < 0 ? 16'd0 :
            (it.write_value > 65535 ? 16'hffff : 16'(it.write_value));
        return 1'b0;
      end
      default: begin
        nd = type_dims[t];
        if (nd == 0) return 1'b1;
        for (int i = 0; i < nd; i++) begin
          idx[i] = search_bin(t, i, c[i]);
          if (idx[i] < 0) return 1'b1;
        end
        addr = type_off[t];
        factor = 1;
        for (int i = nd - 1; i >= 0; i--) begin
          addr += idx[i] * factor;
          factor *= bin_cnt[t][i];
        end
        if (addr > 65535) return 1'b1;
        r.bin_address = addr[15:0];
        r.found = 1'b1;
        return 1'b1;
      end
    endcase
  endfunction

  // True when a lookup would read only written edges.
  function automatic bit edges_known(input in_item_t it);
    int t, nd;
    t = it.bin_type;
    nd = type_dims[t];
    for (int i = 0; i < nd; i++)
      for (int j = 0; j < bin_cnt[t][i]; j++)
        if (!edge_set[t][i][j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 32'($urandom);
      default: return $signed(32'($urandom_range(0, 4000))) - 500;
    endcase
  endfunction

  function automatic in_item_t mk(action_e a, int t, int d, int e,
                                  logic signed [31:0] v, int nd);
    in_item_t it;
    it = '0;
    it.action = a; it.bin_type = 2'(t); it.dim_sel = 2'(d);
    it.entry_sel = 4'(e); it.write_value = v; it.dims_in_use = 3'(nd);
    it.coord_0 = rand_coord(); it.coord_1 = rand_coord();
    it.coord_2 = rand_coord(); it.coord_3 = rand_coord();
    return it;
  endfunction

  // Shadow copy used while generating, so lookups only touch written edges.
  task automatic queue_item(input in_item_t it);
    res_item_t r;
    if (it.action == ACT_LOOKUP && !edges_known(it)) return;
    void'(predict_bin(it, r));
    pending_items.insert(pending_items.size(), it);
  endtask

  // Load one type with sorted edges: random bin count per dimension.
  task automatic load_type(int t, int nd, int maxb, logic signed [31:0] off);
    int nb, step, base;
    for (int d = 0; d < NDims; d++) begin
      nb = $urandom_range(1, maxb);
      base = $urandom_range(0, 200);
      step = $urandom_range(1, 300);
      for (int j = 0; j < nb; j++)
        queue_item(mk(ACT_EDGE, t, d, j, base + j * step, 0));
      queue_item(mk(ACT_COUNT, t, d, 0, nb, 0));
    end
    queue_item(mk(ACT_HEADER, t, 0, 0, off, nd));
  endtask

  initial begin
    in_item_t it;
    for (int t = 0; t < NTypes; t++) begin
      type_dims[t] = '0; type_off[t] = '0;
      for (int d = 0; d < NDims; d++) begin
        bin_cnt[t][d] = '0;
        for (int j = 0; j < NBins; j++) edge_set[t][d][j] = 1'b0;
      end
    end
    // Directed: absent type, full tables, extremes and clamps.
    queue_item(mk(ACT_LOOKUP, 0, 0, 0, 0, 0));
    for (int j = 0; j < NBins; j++)
      queue_item(mk(ACT_EDGE, 1, 0, j,
                    j == 0 ? 32'sh80000000 : j * 100, 0));
    queue_item(mk(ACT_COUNT, 1, 0, 0, 32'sh7fffffff, 0));
    queue_item(mk(ACT_HEADER, 1, 3, 15, 32'sh7fffffff, 7));
    queue_item(mk(ACT_LOOKUP, 1, 0, 0, 0, 0));
    queue_item(mk(ACT_HEADER, 1, 0, 0, 32'sh80000000, 1));
    it = mk(ACT_LOOKUP, 1, 0, 0, 0, 0); it.coord_0 = 32'sh7fffffff;
    queue_item(it);
    it.coord_0 = 32'sh80000000; queue_item(it);
    queue_item(mk(ACT_COUNT, 1, 0, 0, -5, 0));
    queue_item(it);
    queue_item(mk(ACT_COUNT, 1, 0, 0, NBins, 0));
    queue_item(mk(ACT_EDGE, 2, 0, 0, 1000, 0));
    queue_item(mk(ACT_COUNT, 2, 0, 0, 1, 0));
    queue_item(mk(ACT_HEADER, 2, 0, 0, 65535, 1));
    it = mk(ACT_LOOKUP, 2, 0, 0, 0, 0); it.coord_0 = 999; queue_item(it);
    it.coord_0 = 1000; queue_item(it);
    queue_item(mk(ACT_HEADER, 3, 0, 0, 5, 2));
    queue_item(mk(ACT_LOOKUP, 3, 0, 0, 0, 0));
    // Random: mostly lookups, with occasional table loads and some noise writes.
    while (pending_items.size() < 1300) begin
      if ($urandom_range(0, 9) == 0)
        load_type($urandom_range(0, 3), $urandom_range(0, 7),
                  $urandom_range(0, 3) == 0 ? NBins : 4,
                  $urandom_range(0, 3) == 0 ? 32'($urandom) : $urandom_range(0, 70000));
      else if ($urandom_range(0, 19) == 0)
        queue_item(mk(action_e'($urandom_range(1, 2)), $urandom_range(0, 3),
                      $urandom_range(0, 3), $urandom_range(0, 15),
                      $signed(32'($urandom_range(0, 40))) - 10, $urandom_range(0, 7)));
      else
        queue_item(mk(ACT_LOOKUP, $urandom_range(0, 3), $urandom_range(0, 3),
                      $urandom_range(0, 15), 32'($urandom), $urandom_range(0, 7)));
    end
    // Reset shadow state for the run-time predictor.
    for (int t = 0; t < NTypes; t++) begin
      type_dims[t] = '0; type_off[t] = '0;
      for (int d = 0; d < NDims; d++) bin_cnt[t][d] = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
  end

  // Handshakes as seen at the rising edge.
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  always @(posedge clk_i) begin
    in_taken = rst_ni && push_i && !full_o;
    out_taken = rst_ni && pop_i && !empty_o;
  end

  // Driver: one beat per pending item, random gap after each accepted beat.
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        res_item_t r;
        if (predict_bin(in_item_i, r)) expected_bins.insert(expected_bins.size(), r);
        void'(pending_items.pop_front());
        send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0;
      end
      if (send_gap > 0) begin
        push_i <= 1'b0;
        send_gap--;
      end else if (pending_items.size() > 0) begin
        push_i <= 1'b1;
        in_item_i <= pending_items[0];
      end else begin
        push_i <= 1'b0;
        stim_done = 1'b1;
      end
    end
  end

  // Long receiver hold-off once, early in the run.
  initial begin
    @(posedge rst_ni);
    repeat (200) @(posedge clk_i);
    hold_pop = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_pop = 1'b0;
  end

  int pop_gap = 0;
  always @(negedge clk_i) begin
    if (pop_gap > 0) pop_gap--;
    else if (out_taken)
      pop_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0;
    pop_i <= rst_ni && !hold_pop && pop_gap == 0;
  end

  // Monitor: compare each popped beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_bins.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        res_item_t exp_r;
        exp_r = expected_bins.pop_front();
        if (res_o.found !== exp_r.found)
          report($sformatf("found %b, want %b", res_o.found, exp_r.found));
        if (res_o.bin_address !== exp_r.bin_address)
          report($sformatf("bin_address %0d, want %0d",
                           res_o.bin_address, exp_r.bin_address));
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    while (!(stim_done && expected_bins.size() == 0) && cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CycleLimit) begin
      $display("FAILED: results differ");
    end else begin
      repeat (200) @(posedge clk_i);
      if (expected_bins.size() != 0) mismatches++;
      if (mismatches == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mhbl_pkg.sv
rtl/core/mhbl_front.sv
rtl/core/mhbl_back.sv
rtl/core/multidim_histogram_bin_lookup.sv
rtl/core/mhbl_checker.sv
dv/multidim_histogram_bin_lookup_test.sv
